// File: rtl/core/sha256_nonce_trailing_zero_check_assert.svh
// Assertion macros for the SHA-256 nonce checker.
// Included by the RTL files that carry assertions; expects clk and arst_n in scope.
`ifndef SHA256_NONCE_TRAILING_ZERO_CHECK_ASSERT_SVH
`define SHA256_NONCE_TRAILING_ZERO_CHECK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SNTZC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("sntzc assertion failed");
`define SNTZC_ASSERT_NR(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("sntzc assertion failed during reset");
`else
`define SNTZC_ASSERT(lbl, prop)
`define SNTZC_ASSERT_NR(lbl, prop)
`endif
`endif

// File: rtl/core/sntzc_pkg.sv
// Shared types, SHA-256 constants and round functions for the nonce checker.
// No dependencies.
package sntzc_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TRY  = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_PREFIX_LENGTH = 1'b0,
		REG_DIFFICULTY    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  word_index;
		logic [63:0] prefix_word;
		logic [63:0] nonce;
	} req_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_number;
		logic [8:0]  zero_bits;
		logic        meets_difficulty;
		logic [63:0] tried_nonce;
		logic        last;
	} rsp_t;

	// one hash pipeline stage: working vars, chaining value, schedule window
	typedef struct packed {
		word_t [0:7]  st;
		word_t [0:7]  hin;
		word_t [0:15] win;
		word_t [0:15] blk2;
		logic         two;
		logic [63:0]  nonce;
	} pipe_t;

	localparam word_t [0:7] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t [0:63] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t bsig0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

endpackage

// File: rtl/core/sntzc_msg.sv
// Prefix word store, padded message assembly and first pipeline register.
// Depends on sntzc_pkg.
module sntzc_msg import sntzc_pkg::*; #(
	parameter int PREFIX_BYTES_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       fire,
	input  req_t       req,
	input  logic [6:0] prefix_length,
	output logic       vld_s1,
	output pipe_t      data_s1
);

	localparam int STORE_WORDS = (PREFIX_BYTES_MAX + 7) / 8;

	logic [63:0] store_q [STORE_WORDS];
	logic [6:0]  len;
	logic [6:0]  n;
	logic        two;
	logic [63:0] bits;
	logic [7:0]  msg [128];
	pipe_t       init;

	// loads past the store are dropped
	for (genvar j = 0; j < STORE_WORDS; j++) begin : g_store
		always_ff @(posedge clk) begin
			if (fire && req.opcode == OP_LOAD && req.word_index == 3'(j))
				store_q[j] <= req.prefix_word;
		end
	end

	always_comb begin
		len = (prefix_length > 7'(PREFIX_BYTES_MAX)) ? 7'(PREFIX_BYTES_MAX) : prefix_length;
		n = len + 7'd8;
		two = (len >= 7'd48);
		bits = {54'd0, n, 3'd0};
		for (int p = 0; p < 128; p++) begin
			msg[p] = 8'h00;
		end
		for (int p = 0; p < PREFIX_BYTES_MAX; p++) begin
			if (7'(p) < len)
				msg[p] = store_q[p >> 3][56 - 8 * (p & 7) +: 8];
		end
		for (int p = 0; p < 128; p++) begin
			for (int k = 0; k < 8; k++) begin
				if (8'(p) == {1'b0, len} + 8'(k))
					msg[p] = msg[p] | req.nonce[8 * k +: 8];
			end
			if (8'(p) == {1'b0, n})
				msg[p] = msg[p] | 8'h80;
		end
		// length field closes the last block
		for (int k = 0; k < 8; k++) begin
			if (two)
				msg[127 - k] = msg[127 - k] | bits[8 * k +: 8];
			else
				msg[63 - k] = msg[63 - k] | bits[8 * k +: 8];
		end
		init.st = IV;
		init.hin = IV;
		for (int j = 0; j < 16; j++) begin
			init.win[j] = {msg[4 * j], msg[4 * j + 1], msg[4 * j + 2], msg[4 * j + 3]};
			init.blk2[j] = {msg[64 + 4 * j], msg[65 + 4 * j], msg[66 + 4 * j],
				msg[67 + 4 * j]};
		end
		init.two = two;
		init.nonce = req.nonce;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= fire && req.opcode == OP_TRY;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= init;
	end

endmodule

// File: rtl/core/sntzc_round.sv
// One registered SHA-256 compression round with its message schedule step.
// Depends on sntzc_pkg.
module sntzc_round import sntzc_pkg::*; #(
	parameter int ROUND = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld,
	input  pipe_t d,
	output logic  vld_s1,
	output pipe_t data_s1
);

	word_t t1, t2, wnew;
	pipe_t nxt;

	always_comb begin
		t1 = d.st[7] + bsig1(d.st[4]) + ((d.st[4] & d.st[5]) ^ (~d.st[4] & d.st[6]))
			+ ROUND_K[ROUND] + d.win[0];
		t2 = bsig0(d.st[0]) + ((d.st[0] & d.st[1]) ^ (d.st[0] & d.st[2])
			^ (d.st[1] & d.st[2]));
		wnew = d.win[0] + ssig0(d.win[1]) + d.win[9] + ssig1(d.win[14]);
		nxt = d;
		nxt.st = {t1 + t2, d.st[0], d.st[1], d.st[2], d.st[3] + t1, d.st[4], d.st[5],
			d.st[6]};
		nxt.win = {d.win[1:15], wnew};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s1 <= nxt;
	end

endmodule

// File: rtl/core/sntzc_tzc.sv
// Two-stage trailing zero count over the 256-bit digest.
// Depends on sntzc_pkg.
module sntzc_tzc import sntzc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         vld,
	input  logic [255:0] digest,
	input  logic [63:0]  nonce,
	output logic         vld_s2,
	output logic [255:0] digest_s2,
	output logic [63:0]  nonce_s2,
	output logic [8:0]   zeros_s2
);

	logic [5:0]   lane_cnt [8];
	logic [5:0]   lane_s1 [8];
	logic         vld_s1;
	logic [255:0] digest_s1;
	logic [63:0]  nonce_s1;
	logic [8:0]   zsum;
	logic         hit;

	// lane 0 is the least significant word of the digest
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			lane_cnt[j] = 6'd32;
			for (int b = 31; b >= 0; b--) begin
				if (digest[32 * j + b])
					lane_cnt[j] = 6'(b);
			end
		end
	end

	always_comb begin
		zsum = 9'd0;
		hit = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if (!hit) begin
				zsum = zsum + {3'd0, lane_s1[j]};
				hit = (lane_s1[j] != 6'd32);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_cnt;
			digest_s1 <= digest;
			nonce_s1 <= nonce;
			digest_s2 <= digest_s1;
			nonce_s2 <= nonce_s1;
			zeros_s2 <= zsum;
		end
	end

endmodule

// File: rtl/core/sha256_nonce_trailing_zero_check.sv
// SHA-256 proof-of-work nonce checker, top level: config regs, hash pipeline, result serialiser.
// Depends on sntzc_pkg, sntzc_msg, sntzc_round, sntzc_tzc and the assertion header.
//
// Loads write one prefix word and are taken one per cycle while the pipeline is not held. A try
// runs through a fully unrolled pipeline: one message assembly stage, 64 round stages, a feed-forward
// stage, 64 more round stages for the second block, a final feed-forward and two trailing-zero
// stages. A new try enters every cycle when nothing stalls, but each try leaves as four result
// words through the output serialiser, so back-to-back tries are limited by the serialiser; the whole
// pipeline holds while a finished digest waits for the busy serialiser. No clearing pass after reset.
// Configuration must only change while idle.
`include "sha256_nonce_trailing_zero_check_assert.svh"
module sha256_nonce_trailing_zero_check import sntzc_pkg::*; #(
	parameter int PREFIX_BYTES_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [6:0]   prefix_length_q;
	logic [8:0]   difficulty_q;
	logic         adv;
	logic         take;
	pipe_t        b1_d [65];
	logic         b1_v [65];
	pipe_t        b2_d [65];
	logic         b2_v [65];
	pipe_t        mid;
	logic [255:0] dig;
	logic [255:0] dig_s1;
	logic [63:0]  nonce_s1;
	logic         dig_vld_s1;
	logic         tz_vld;
	logic [255:0] tz_digest;
	logic [63:0]  tz_nonce;
	logic [8:0]   tz_zeros;
	logic         ser_vld_q;
	logic [1:0]   word_q;
	logic [255:0] dig_q;
	logic [8:0]   zeros_q;
	logic         meets_q;
	logic [63:0]  nonce_q;

	// APB config
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DIFFICULTY) ? {23'd0, difficulty_q}
		: {25'd0, prefix_length_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_length_q <= 7'd0;
			difficulty_q <= 9'd0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_PREFIX_LENGTH: prefix_length_q <= pwdata[6:0];
				REG_DIFFICULTY:    difficulty_q <= pwdata[8:0];
				default:           ;
			endcase
		end
	end

	// whole pipeline holds while a finished digest waits for the serialiser
	assign take = tz_vld && (!ser_vld_q || (rsp_ready && word_q == 2'd3));
	assign adv = !tz_vld || take;
	assign req_ready = adv;

	sntzc_msg #(.PREFIX_BYTES_MAX(PREFIX_BYTES_MAX)) u_msg (
		.clk(clk), .arst_n(arst_n), .en(adv), .fire(req_valid && req_ready), .req(req),
		.prefix_length(prefix_length_q), .vld_s1(b1_v[0]), .data_s1(b1_d[0])
	);

	for (genvar r = 0; r < 64; r++) begin : g_blk1
		sntzc_round #(.ROUND(r)) u_round (
			.clk(clk), .arst_n(arst_n), .en(adv), .vld(b1_v[r]), .d(b1_d[r]),
			.vld_s1(b1_v[r + 1]), .data_s1(b1_d[r + 1])
		);
	end

	always_comb begin
		mid = b1_d[64];
		for (int j = 0; j < 8; j++) begin
			mid.st[j] = b1_d[64].hin[j] + b1_d[64].st[j];
			mid.hin[j] = b1_d[64].hin[j] + b1_d[64].st[j];
		end
		mid.win = b1_d[64].blk2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b2_v[0] <= 1'b0;
		end else if (adv) begin
			b2_v[0] <= b1_v[64];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			b2_d[0] <= mid;
	end

	for (genvar r = 0; r < 64; r++) begin : g_blk2
		sntzc_round #(.ROUND(r)) u_round (
			.clk(clk), .arst_n(arst_n), .en(adv), .vld(b2_v[r]), .d(b2_d[r]),
			.vld_s1(b2_v[r + 1]), .data_s1(b2_d[r + 1])
		);
	end

	// single-block messages keep the first block's chaining value
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			dig[255 - 32 * j -: 32] = b2_d[64].two ? b2_d[64].hin[j] + b2_d[64].st[j]
				: b2_d[64].hin[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_vld_s1 <= 1'b0;
		end else if (adv) begin
			dig_vld_s1 <= b2_v[64];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dig_s1 <= dig;
			nonce_s1 <= b2_d[64].nonce;
		end
	end

	sntzc_tzc u_tzc (
		.clk(clk), .arst_n(arst_n), .en(adv), .vld(dig_vld_s1), .digest(dig_s1),
		.nonce(nonce_s1), .vld_s2(tz_vld), .digest_s2(tz_digest), .nonce_s2(tz_nonce),
		.zeros_s2(tz_zeros)
	);

	// result serialiser: four words per try
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			word_q <= 2'd0;
		end else if (take) begin
			ser_vld_q <= 1'b1;
			word_q <= 2'd0;
		end else if (ser_vld_q && rsp_ready) begin
			if (word_q == 2'd3)
				ser_vld_q <= 1'b0;
			else
				word_q <= word_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dig_q <= tz_digest;
			zeros_q <= tz_zeros;
			meets_q <= (tz_zeros >= difficulty_q);
			nonce_q <= tz_nonce;
		end
	end

	assign rsp_valid = ser_vld_q;

	always_comb begin
		unique case (word_q)
			2'd0:    rsp.digest_word = dig_q[255:192];
			2'd1:    rsp.digest_word = dig_q[191:128];
			2'd2:    rsp.digest_word = dig_q[127:64];
			default: rsp.digest_word = dig_q[63:0];
		endcase
		rsp.word_number = word_q;
		rsp.zero_bits = zeros_q;
		rsp.meets_difficulty = meets_q;
		rsp.tried_nonce = nonce_q;
		rsp.last = (word_q == 2'd3);
	end

	`SNTZC_ASSERT(a_meets_flag, rsp_valid |-> (rsp.meets_difficulty == (rsp.zero_bits >= difficulty_q)))
	`SNTZC_ASSERT(a_word_step, (rsp_valid && rsp_ready && !rsp.last) |=> (rsp_valid && rsp.word_number == $past(rsp.word_number) + 2'd1))
	`SNTZC_ASSERT(a_stall_blocks_input, (tz_vld && !take) |-> !req_ready)
	`SNTZC_ASSERT_NR(a_reset_quiet, !arst_n |-> !rsp_valid)

endmodule

// File: bench/sha256_nonce_trailing_zero_check_test.sv
// Testbench for the SHA-256 nonce checker: directed table, then random loads and tries.
// Needs sntzc_pkg and sha256_nonce_trailing_zero_check; hashes are predicted locally.
`timescale 1ns / 100ps
module sha256_nonce_trailing_zero_check_test;
	import sntzc_pkg::*;

	localparam int LATENCY_WAIT = 160;
	localparam logic [2:0] ADDR_PLEN = 3'(4 * REG_PREFIX_LENGTH);
	localparam logic [2:0] ADDR_DIFF = 3'(4 * REG_DIFFICULTY);
	localparam int MEETS_FROM_MODEL = -1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sha256_nonce_trailing_zero_check u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the block's state
	logic [63:0] prefix_words [0:7];
	logic [6:0]  plen_reg;
	logic [8:0]  diff_reg;
	rsp_t        digest_q [$];

	int n_errors, n_tries, n_loads, n_words, n_met;
	int long_hold;
	bit calm;

	initial begin
		#2ms;
		$display("timeout: %0d digest words still awaited", digest_q.size());
		$display("[sha256_nonce_trailing_zero_check] ERROR");
		$finish;
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		$display("%t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] sha_blocks(logic [7:0] msg [0:127], int nblk);
		logic [31:0] st [0:7];
		logic [31:0] w [0:63];
		logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
		for (int i = 0; i < 8; i++) st[i] = IV[i];
		for (int blk = 0; blk < nblk; blk++) begin
			for (int i = 0; i < 16; i++)
				w[i] = {msg[64*blk+4*i], msg[64*blk+4*i+1], msg[64*blk+4*i+2],
					msg[64*blk+4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			a = st[0]; b = st[1]; c = st[2]; d = st[3];
			e = st[4]; f = st[5]; g = st[6]; hh = st[7];
			for (int i = 0; i < 64; i++) begin
				t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
					+ ROUND_K[i] + w[i];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				hh = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			st[0] += a; st[1] += b; st[2] += c; st[3] += d;
			st[4] += e; st[5] += f; st[6] += g; st[7] += hh;
		end
		return {st[0], st[1], st[2], st[3], st[4], st[5], st[6], st[7]};
	endfunction

	// applies one accepted transaction to the shadow state and queues its digest words
	task automatic predict_try(req_t r, int meets_override);
		logic [7:0]   msg [0:127];
		logic [255:0] dig;
		logic [63:0]  nbits;
		int len, n, nblk, zeros;
		rsp_t o;
		if (r.opcode == OP_LOAD) begin
			prefix_words[r.word_index] = r.prefix_word;
			n_loads++;
			return;
		end
		len = (plen_reg > 64) ? 64 : plen_reg;
		for (int i = 0; i < 128; i++) msg[i] = 8'h00;
		for (int i = 0; i < len; i++) msg[i] = prefix_words[i / 8][63 - 8 * (i % 8) -: 8];
		for (int i = 0; i < 8; i++) msg[len + i] = r.nonce[8 * i +: 8];
		n = len + 8;
		msg[n] = 8'h80;
		nblk = (n + 9 + 63) / 64;
		nbits = 64'(n) * 8;
		for (int i = 0; i < 8; i++) msg[nblk * 64 - 1 - i] = nbits[8 * i +: 8];
		dig = sha_blocks(msg, nblk);
		zeros = 0;
		while (zeros < 256 && !dig[zeros]) zeros++;
		n_tries++;
		for (int k = 0; k < 4; k++) begin
			o.digest_word = dig[255 - 64 * k -: 64];
			o.word_number = 2'(k);
			o.zero_bits = 9'(zeros);
			o.meets_difficulty = (meets_override == MEETS_FROM_MODEL) ?
				(zeros >= diff_reg) : meets_override[0];
			o.tried_nonce = r.nonce;
			o.last = (k == 3);
			digest_q.push_back(o);
		end
	endtask

	task automatic check_word(rsp_t got);
		rsp_t want;
		if (digest_q.size() == 0) begin
			report("unexpected digest word", got.digest_word, '0);
			return;
		end
		want = digest_q.pop_front();
		n_words++;
		if (got.last && got.meets_difficulty) n_met++;
		if (got.digest_word !== want.digest_word)
			report("digest_word", got.digest_word, want.digest_word);
		if (got.word_number !== want.word_number)
			report("word_number", got.word_number, want.word_number);
		if (got.zero_bits !== want.zero_bits) report("zero_bits", got.zero_bits, want.zero_bits);
		if (got.meets_difficulty !== want.meets_difficulty)
			report("meets_difficulty", got.meets_difficulty, want.meets_difficulty);
		if (got.tried_nonce !== want.tried_nonce)
			report("tried_nonce", got.tried_nonce, want.tried_nonce);
		if (got.last !== want.last) report("last", got.last, want.last);
	endtask

	// result side: random stalls, plus an occasional long hold-off
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				check_word(rsp);
				stall = calm ? 0 : $urandom_range(0, 4);
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else
				rsp_ready <= 1'b1;
		end
	end

	task automatic send(req_t r, int meets_override, bit no_gap);
		int gap;
		gap = (calm || no_gap) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		predict_try(r, meets_override);
	endtask

	task automatic drain(bit settle);
		req_valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		if (settle) repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		drain(1'b1);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_PLEN) plen_reg = value[6:0];
		else if (addr == ADDR_DIFF) diff_reg = value[8:0];
	endtask

	function automatic req_t mk(opcode_t op, int idx, logic [63:0] word, logic [63:0] nonce);
		req_t r;
		r.opcode = op;
		r.word_index = 3'(idx);
		r.prefix_word = word;
		r.nonce = nonce;
		return r;
	endfunction

	function automatic req_t random_item(int load_pct);
		req_t r;
		r.word_index = 3'($urandom);
		r.prefix_word = {$urandom, $urandom};
		r.nonce = {$urandom, $urandom};
		r.opcode = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_TRY;
		case ($urandom_range(0, 9))
			0: r.nonce = '0;
			1: r.nonce = '1;
			default: ;
		endcase
		return r;
	endfunction

	typedef struct {
		bit          is_cfg;
		logic [2:0]  addr;
		logic [31:0] value;
		req_t        item;
		int          meets;
	} step_t;

	step_t steps [$];

	function automatic step_t cfg(logic [2:0] addr, int value);
		step_t s;
		s.is_cfg = 1'b1; s.addr = addr; s.value = value; s.item = '0; s.meets = 0;
		return s;
	endfunction

	function automatic step_t itm(req_t r, int meets);
		step_t s;
		s.is_cfg = 1'b0; s.addr = '0; s.value = '0; s.item = r; s.meets = meets;
		return s;
	endfunction

	initial begin
		int plens [8] = '{0, 1, 47, 48, 55, 56, 64, 127};
		n_errors = 0; n_tries = 0; n_loads = 0; n_words = 0; n_met = 0;
		long_hold = 0; calm = 1'b0;
		plen_reg = '0; diff_reg = '0;
		for (int i = 0; i < 8; i++) prefix_words[i] = '0;

		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every word is loaded before the first try, so no unwritten word is ever hashed
		steps.push_back(itm(mk(OP_LOAD, 0, 64'h0, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 1, '1, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 2, 64'h0123456789abcdef, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 3, 64'h8000000000000001, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 4, 64'ha5a5a5a5a5a5a5a5, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 5, 64'h5a5a5a5a5a5a5a5a, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 6, 64'hfedcba9876543210, '0), 0));
		steps.push_back(itm(mk(OP_LOAD, 7, 64'h7fffffffffffffff, '0), 0));
		// after reset: empty prefix, zero difficulty is always met
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h0), 1));
		steps.push_back(itm(mk(OP_TRY, 0, '0, '1), 1));
		steps.push_back(cfg(ADDR_PLEN, 47));
		steps.push_back(cfg(ADDR_DIFF, 300));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h1), 0));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h8000000000000000), 0));
		steps.push_back(cfg(ADDR_PLEN, 48));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h0), 0));
		steps.push_back(cfg(ADDR_PLEN, 64));
		steps.push_back(cfg(ADDR_DIFF, 256));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'hdeadbeefcafef00d), 0));
		// length above the store saturates to 64 bytes
		steps.push_back(cfg(ADDR_PLEN, 127));
		steps.push_back(cfg(ADDR_DIFF, 0));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h0123456789abcdef), 1));
		steps.push_back(cfg(ADDR_DIFF, 511));
		steps.push_back(itm(mk(OP_TRY, 0, '0, 64'h0123456789abcdef), 0));

		foreach (steps[i]) begin
			if (steps[i].is_cfg) write_reg(steps[i].addr, steps[i].value);
			else send(steps[i].item, steps[i].meets, 1'b0);
		end

		// random phases: length and difficulty change between them, only when idle
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ADDR_PLEN, plens[ph]);
			write_reg(ADDR_DIFF, (ph == 7) ? 9'd511 : $urandom_range(0, 3));
			calm = (ph == 2);
			if (ph == 4) begin
				// receiver holds off while tries keep coming; more tries than pipeline
				// stages, so the block backs up and stalls its input
				long_hold = 400;
				for (int i = 0; i < 140; i++) send(random_item(0), MEETS_FROM_MODEL, 1'b1);
			end else
				for (int i = 0; i < 12; i++) begin
					send(random_item(25), MEETS_FROM_MODEL, 1'b0);
					if (ph == 5 && i == 6) drain(1'b0);
				end
		end
		calm = 1'b0;

		drain(1'b1);
		$display("covered %0d tries and %0d loads, %0d digest words checked, %0d tries met",
			n_tries, n_loads, n_words, n_met);
		$display("prefix lengths 0 to 127 (one and two blocks), difficulty 0 to 511");
		if (n_errors == 0)
			$display("[sha256_nonce_trailing_zero_check] OK");
		else
			$display("[sha256_nonce_trailing_zero_check] ERROR");
		$finish;
	end

endmodule
